>>> rtl/quaternion_arithmetic_unit_top_assert.svh
// ----------------------------------------------------------------------------
// quaternion unit assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// same-cycle implication, reset masked
`define QAU_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define QAU_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// widths, request and result types and operation codes of the quaternion unit
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 27;
  localparam int NORM_EXTRA    = 15;

  // derived widths
  localparam int PW     = 2 * WORD_BITS;
  localparam int HW     = PW + 2;
  localparam int N2W    = PW + 1;
  localparam int XW     = N2W + 2 * NORM_EXTRA;
  localparam int SXW    = XW + (XW % 2);
  localparam int RB     = SXW / 2;
  localparam int DW     = (N2W > RB) ? N2W : RB;
  localparam int SH_INV = 2 * FRACTION_BITS;
  localparam int SH_NRM = FRACTION_BITS + NORM_EXTRA;
  localparam int SHMAX  = (SH_INV > SH_NRM) ? SH_INV : SH_NRM;
  localparam int NW     = WORD_BITS + SHMAX;
  localparam int QB     = WORD_BITS + 1;
  localparam int MGW    = ((QB > RB) ? QB : RB) + 1;
  localparam int CW     = ((NW > DW) ? NW : DW) + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PW-1:0]        prod_t;
  typedef logic signed [HW-1:0]        hsum_t;
  typedef hsum_t [3:0]                 hvec_t;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_CONJ  = 4'd2,
    OP_SCALE = 4'd3,
    OP_MUL   = 4'd4,
    OP_INV   = 4'd5,
    OP_NRM   = 4'd6,
    OP_NORM  = 4'd7,
    OP_FRAME = 4'd8
  } op_t;

  typedef struct packed {
    logic [3:0] req_type;
    word_t      q_real;
    word_t      q_i;
    word_t      q_j;
    word_t      q_k;
    word_t      p_real;
    word_t      p_i;
    word_t      p_j;
    word_t      p_k;
    word_t      scale_factor;
  } req_t;

  typedef struct packed {
    word_t res_real;
    word_t res_i;
    word_t res_j;
    word_t res_k;
    logic  saturated;
    logic  zero_magnitude;
  } res_t;

  typedef struct packed {
    logic  sat;
    word_t v;
  } wsat_t;

  // request context travelling down the pipe
  typedef struct packed {
    op_t              op;
    word_t [3:0]      q;
    word_t [3:0]      t;
    logic             sat;
    logic             zero;
    logic [N2W-1:0]   n2;
  } carry_t;

  typedef struct packed {
    logic [RB:0]    r;
    logic [RB-1:0]  y;
    logic [SXW-1:0] x;
  } sq_t;

  typedef struct packed {
    logic [DW-1:0] r;
    logic [QB-1:0] q;
    logic [QB-1:0] nl;
    logic          ovf;
    logic          neg;
  } dl_t;

  typedef dl_t [3:0] dlv_t;

endpackage

>>> rtl/quaternion_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_top
// pipelined quaternion arithmetic unit, Q4.27 fixed point with saturation
// ----------------------------------------------------------------------------
// Usage: a request (req, req_valid/req_ready) carries the operation code,
// quaternions q and p and a scalar; one result (res, res_valid/res_ready)
// comes back per request, in request order.
// Every operation takes the same path: three multiply/sum/round stages,
// 48 square-root stages (one root bit each), a divider set-up stage, 33
// divider stages (one quotient bit each, four lanes), a finishing stage and
// three stages for the second Hamilton product, the last being the output
// register. One request is taken per cycle for as long as results drain.
// Throughput: the single-bit-per-stage root and divider chains are fully
// pipelined, so one request per cycle is taken while results drain.
// Reset clears every stage valid bit; the pipe is empty after reset.
// When the receiver stalls the whole pipe holds, req_ready drops and the
// waiting result stays unchanged on res until it is taken.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  qau_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output qau_pkg::res_t res
);

  localparam int W   = qau_pkg::WORD_BITS;
  localparam int F   = qau_pkg::FRACTION_BITS;
  localparam int NE  = qau_pkg::NORM_EXTRA;
  localparam int HW  = qau_pkg::HW;
  localparam int SXW = qau_pkg::SXW;
  localparam int RB  = qau_pkg::RB;
  localparam int DW  = qau_pkg::DW;
  localparam int NW  = qau_pkg::NW;
  localparam int QB  = qau_pkg::QB;
  localparam int MGW = qau_pkg::MGW;
  localparam int CW  = qau_pkg::CW;

  localparam logic signed [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [HW-1:0] HALF = {{(HW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [MGW-1:0]       MAXU = {{(MGW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [MGW-1:0]       MINM = {{(MGW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic qau_pkg::wsat_t sat_small(input logic signed [W:0] v);
    qau_pkg::wsat_t r;
    r.sat = (v[W] != v[W-1]);
    r.v   = r.sat ? (v[W] ? WMIN : WMAX) : v[W-1:0];
    return r;
  endfunction

  function automatic qau_pkg::wsat_t rnd_sat(input qau_pkg::hsum_t h);
    logic signed [HW-1:0] s;
    qau_pkg::wsat_t       r;
    s     = (h + HALF) >>> F;
    r.sat = !((&s[HW-1:W-1]) || !(|s[HW-1:W-1]));
    r.v   = r.sat ? (s[HW-1] ? WMIN : WMAX) : s[W-1:0];
    return r;
  endfunction

  function automatic qau_pkg::wsat_t sat_mag(input logic [MGW-1:0] m, input logic neg);
    logic [MGW-1:0] n;
    qau_pkg::wsat_t r;
    n = -m;
    if (!neg) begin
      r.sat = (m > MAXU);
      r.v   = r.sat ? WMAX : m[W-1:0];
    end else begin
      r.sat = (m > MINM);
      r.v   = r.sat ? WMIN : n[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [W-1:0] umag(input qau_pkg::word_t v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic qau_pkg::hsum_t sx(input qau_pkg::prod_t p);
    return {{(HW-qau_pkg::PW){p[qau_pkg::PW-1]}}, p};
  endfunction

  // hamilton product sums from the sixteen cross products a[x]*b[y]
  function automatic qau_pkg::hvec_t ham(input qau_pkg::prod_t p [16]);
    qau_pkg::hvec_t r;
    r[0] = sx(p[0]) - sx(p[5]) - sx(p[10]) - sx(p[15]);
    r[1] = sx(p[1]) + sx(p[4]) + sx(p[11]) - sx(p[14]);
    r[2] = sx(p[2]) - sx(p[7]) + sx(p[8]) + sx(p[13]);
    r[3] = sx(p[3]) + sx(p[6]) - sx(p[9]) + sx(p[12]);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // pipe control: whole pipe moves when the output register is free
  // --------------------------------------------------------------------------
  logic en;
  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  logic          v1, v2, v3, vp, vf, vm, vs;
  logic [RB-1:0] sv;
  logic [QB-1:0] dvv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      sv        <= '0;
      vp        <= 1'b0;
      dvv       <= '0;
      vf        <= 1'b0;
      vm        <= 1'b0;
      vs        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= req_valid;
      v2        <= v1;
      v3        <= v2;
      sv        <= {sv[RB-2:0], v3};
      vp        <= sv[RB-1];
      dvv       <= {dvv[QB-2:0], vp};
      vf        <= dvv[QB-1];
      vm        <= vf;
      vs        <= vm;
      res_valid <= vs;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: cross products, squares of q, add / sub / conjugate
  // --------------------------------------------------------------------------
  qau_pkg::word_t  qv [4];
  qau_pkg::word_t  pv [4];
  qau_pkg::word_t  bsel [4];
  qau_pkg::prod_t  m1 [16];
  qau_pkg::prod_t  pr1 [16];
  qau_pkg::prod_t  sq1 [4];
  qau_pkg::prod_t  sqr1 [4];
  qau_pkg::carry_t c1_next, c1;
  qau_pkg::wsat_t  e1 [4];

  always_comb begin
    qv[0] = req.q_real;
    qv[1] = req.q_i;
    qv[2] = req.q_j;
    qv[3] = req.q_k;
    pv[0] = req.p_real;
    pv[1] = req.p_i;
    pv[2] = req.p_j;
    pv[3] = req.p_k;
    c1_next      = '0;
    c1_next.op   = qau_pkg::op_t'(req.req_type);
    for (int y = 0; y < 4; y++) begin
      if (c1_next.op == qau_pkg::OP_SCALE) begin
        bsel[y] = req.scale_factor;
      end else begin
        bsel[y] = pv[y];
      end
    end
    for (int x = 0; x < 4; x++) begin
      for (int y = 0; y < 4; y++) begin
        m1[x*4+y] = qv[x] * bsel[y];
      end
    end
    for (int c = 0; c < 4; c++) begin
      sq1[c] = qv[c] * qv[c];
    end
    for (int c = 0; c < 4; c++) begin
      c1_next.q[c] = qv[c];
      case (c1_next.op)
        qau_pkg::OP_ADD:
          e1[c] = sat_small($signed({qv[c][W-1], qv[c]}) + $signed({pv[c][W-1], pv[c]}));
        qau_pkg::OP_SUB:
          e1[c] = sat_small($signed({qv[c][W-1], qv[c]}) - $signed({pv[c][W-1], pv[c]}));
        qau_pkg::OP_CONJ:
          e1[c] = (c == 0) ? sat_small($signed({qv[c][W-1], qv[c]}))
                           : sat_small(-$signed({qv[c][W-1], qv[c]}));
        default:
          e1[c] = '0;
      endcase
      c1_next.t[c] = e1[c].v;
    end
    c1_next.sat = e1[0].sat | e1[1].sat | e1[2].sat | e1[3].sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1   <= c1_next;
      pr1  <= m1;
      sqr1 <= sq1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: product sums, sum of squares
  // --------------------------------------------------------------------------
  qau_pkg::carry_t c2_next, c2;
  qau_pkg::hvec_t  h2_next, h2;

  always_comb begin
    c2_next = c1;
    if (c1.op == qau_pkg::OP_SCALE) begin
      for (int c = 0; c < 4; c++) begin
        h2_next[c] = sx(pr1[c*4]);
      end
    end else begin
      h2_next = ham(pr1);
    end
    c2_next.n2   = {1'b0, sqr1[0]} + {1'b0, sqr1[1]} + {1'b0, sqr1[2]} + {1'b0, sqr1[3]};
    c2_next.zero = (c2_next.n2 == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c2_next;
      h2 <= h2_next;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: round and clip products, root operand
  // --------------------------------------------------------------------------
  qau_pkg::carry_t  c3_next, c3;
  logic [SXW-1:0]   x3_next, x3;
  qau_pkg::wsat_t   e3 [4];

  always_comb begin
    c3_next = c2;
    for (int c = 0; c < 4; c++) begin
      e3[c] = rnd_sat(h2[c]);
    end
    if (c2.op == qau_pkg::OP_SCALE || c2.op == qau_pkg::OP_MUL ||
        c2.op == qau_pkg::OP_FRAME) begin
      for (int c = 0; c < 4; c++) begin
        c3_next.t[c] = e3[c].v;
      end
      c3_next.sat = e3[0].sat | e3[1].sat | e3[2].sat | e3[3].sat;
    end
    if (c2.op == qau_pkg::OP_NORM) begin
      x3_next = SXW'(c2.n2);
    end else begin
      x3_next = SXW'({c2.n2, {(2*NE){1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c3_next;
      x3 <= x3_next;
    end
  end

  // --------------------------------------------------------------------------
  // square root chain, one root bit per stage
  // --------------------------------------------------------------------------
  qau_pkg::sq_t    ss [RB];
  qau_pkg::sq_t    ssn [RB];
  qau_pkg::carry_t sc [RB];

  always_comb begin
    qau_pkg::sq_t    si;
    logic [RB+2:0]   rs;
    logic [RB+2:0]   tt;
    logic [RB+2:0]   df;
    for (int k = 0; k < RB; k++) begin
      if (k == 0) begin
        si.r = '0;
        si.y = '0;
        si.x = x3;
      end else begin
        si = ss[k-1];
      end
      rs = {si.r, si.x[SXW-1 -: 2]};
      tt = {1'b0, si.y, 2'b01};
      df = rs - tt;
      if (rs >= tt) begin
        ssn[k].r = df[RB:0];
        ssn[k].y = {si.y[RB-2:0], 1'b1};
      end else begin
        ssn[k].r = rs[RB:0];
        ssn[k].y = {si.y[RB-2:0], 1'b0};
      end
      ssn[k].x = si.x << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RB; k++) begin
        ss[k] <= ssn[k];
        sc[k] <= (k == 0) ? c3 : sc[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // divider set-up, norm result
  // --------------------------------------------------------------------------
  qau_pkg::carry_t cp_next, cp;
  qau_pkg::dlv_t   pl_next, pl;
  logic [DW-1:0]   pd_next, pd;

  always_comb begin
    logic [RB:0]    nr;
    logic [W-1:0]   m;
    logic [NW-1:0]  nn;
    logic [NW-1:0]  hi;
    qau_pkg::wsat_t ns;
    qau_pkg::sq_t   so;
    so      = ss[RB-1];
    cp_next = sc[RB-1];
    nr      = {1'b0, so.y} + {{RB{1'b0}}, (so.r > {1'b0, so.y})};
    ns      = sat_mag(MGW'(nr), 1'b0);
    if (cp_next.op == qau_pkg::OP_NORM) begin
      cp_next.t[0] = ns.v;
      cp_next.t[1] = '0;
      cp_next.t[2] = '0;
      cp_next.t[3] = '0;
      cp_next.sat  = ns.sat;
    end
    pd_next = (cp_next.op == qau_pkg::OP_NRM) ? DW'(so.y) : DW'(cp_next.n2);
    for (int c = 0; c < 4; c++) begin
      m  = umag(cp_next.q[c]);
      nn = (cp_next.op == qau_pkg::OP_NRM) ? (NW'(m) << qau_pkg::SH_NRM)
                                           : (NW'(m) << qau_pkg::SH_INV);
      hi = nn >> QB;
      pl_next[c].ovf = (CW'(hi) >= CW'(pd_next));
      pl_next[c].r   = DW'(hi);
      pl_next[c].q   = '0;
      pl_next[c].nl  = nn[QB-1:0];
      if (cp_next.op == qau_pkg::OP_NRM || c == 0) begin
        pl_next[c].neg = cp_next.q[c][W-1];
      end else begin
        pl_next[c].neg = !cp_next.q[c][W-1] && (cp_next.q[c] != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp <= cp_next;
      pl <= pl_next;
      pd <= pd_next;
    end
  end

  // --------------------------------------------------------------------------
  // divider chain, four lanes, one quotient bit per stage
  // --------------------------------------------------------------------------
  qau_pkg::dlv_t   dl [QB];
  qau_pkg::dlv_t   dln [QB];
  logic [DW-1:0]   dd [QB];
  qau_pkg::carry_t dc [QB];

  always_comb begin
    qau_pkg::dlv_t li;
    logic [DW-1:0] di;
    logic [DW:0]   rs;
    logic [DW:0]   df;
    logic          ge;
    for (int k = 0; k < QB; k++) begin
      li = (k == 0) ? pl : dl[k-1];
      di = (k == 0) ? pd : dd[k-1];
      for (int c = 0; c < 4; c++) begin
        rs = {li[c].r, li[c].nl[QB-1]};
        df = rs - {1'b0, di};
        ge = (rs >= {1'b0, di});
        dln[k][c].r   = ge ? df[DW-1:0] : rs[DW-1:0];
        dln[k][c].q   = {li[c].q[QB-2:0], ge};
        dln[k][c].nl  = li[c].nl << 1;
        dln[k][c].ovf = li[c].ovf;
        dln[k][c].neg = li[c].neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        dl[k] <= dln[k];
        dd[k] <= (k == 0) ? pd : dd[k-1];
        dc[k] <= (k == 0) ? cp : dc[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // divider finish: round, clip, zero quaternion pass-through
  // --------------------------------------------------------------------------
  qau_pkg::carry_t cf_next, cf;

  always_comb begin
    qau_pkg::dl_t   lo;
    logic [QB:0]    qr;
    qau_pkg::wsat_t vr [4];
    cf_next = dc[QB-1];
    for (int c = 0; c < 4; c++) begin
      lo = dl[QB-1][c];
      qr = {1'b0, lo.q} + {{QB{1'b0}}, ({lo.r, 1'b0} >= {1'b0, dd[QB-1]})};
      if (lo.ovf) begin
        vr[c].sat = 1'b1;
        vr[c].v   = lo.neg ? WMIN : WMAX;
      end else begin
        vr[c] = sat_mag(MGW'(qr), lo.neg);
      end
    end
    if ((cf_next.op == qau_pkg::OP_INV || cf_next.op == qau_pkg::OP_NRM ||
         cf_next.op == qau_pkg::OP_FRAME) && !cf_next.zero) begin
      for (int c = 0; c < 4; c++) begin
        cf_next.q[c] = vr[c].v;
      end
      cf_next.sat = cf_next.sat | vr[0].sat | vr[1].sat | vr[2].sat | vr[3].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cf <= cf_next;
    end
  end

  // --------------------------------------------------------------------------
  // second hamilton product t * inv(q): products, sums
  // --------------------------------------------------------------------------
  qau_pkg::prod_t  m2 [16];
  qau_pkg::prod_t  pr2 [16];
  qau_pkg::carry_t cm, cs;
  qau_pkg::hvec_t  h4;

  always_comb begin
    for (int x = 0; x < 4; x++) begin
      for (int y = 0; y < 4; y++) begin
        m2[x*4+y] = $signed(cf.t[x]) * $signed(cf.q[y]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm  <= cf;
      pr2 <= m2;
      cs  <= cm;
      h4  <= ham(pr2);
    end
  end

  // --------------------------------------------------------------------------
  // output stage: final rounding and result select
  // --------------------------------------------------------------------------
  qau_pkg::res_t  res_next;
  qau_pkg::wsat_t fr [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      fr[c] = rnd_sat(h4[c]);
    end
    res_next = '0;
    case (cs.op)
      qau_pkg::OP_ADD, qau_pkg::OP_SUB, qau_pkg::OP_CONJ, qau_pkg::OP_SCALE,
      qau_pkg::OP_MUL, qau_pkg::OP_NORM: begin
        res_next.res_real  = cs.t[0];
        res_next.res_i     = cs.t[1];
        res_next.res_j     = cs.t[2];
        res_next.res_k     = cs.t[3];
        res_next.saturated = cs.sat;
      end
      qau_pkg::OP_INV, qau_pkg::OP_NRM: begin
        res_next.res_real       = cs.q[0];
        res_next.res_i          = cs.q[1];
        res_next.res_j          = cs.q[2];
        res_next.res_k          = cs.q[3];
        res_next.saturated      = cs.sat;
        res_next.zero_magnitude = cs.zero;
      end
      qau_pkg::OP_FRAME: begin
        res_next.res_real       = fr[0].v;
        res_next.res_i          = fr[1].v;
        res_next.res_j          = fr[2].v;
        res_next.res_k          = fr[3].v;
        res_next.saturated      = cs.sat | fr[0].sat | fr[1].sat | fr[2].sat | fr[3].sat;
        res_next.zero_magnitude = cs.zero;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

>>> rtl/qau_checker.sv
// ----------------------------------------------------------------------------
// qau_checker
// port-level checks of the quaternion unit, bound to the top level
// ----------------------------------------------------------------------------
`include "quaternion_arithmetic_unit_top_assert.svh"

module qau_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input qau_pkg::req_t req,
  input logic          res_valid,
  input logic          res_ready,
  input qau_pkg::res_t res
);

  // a waiting result is held
  `QAU_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid, "result dropped")
  `QAU_ASSERT_NXT(a_res_stable, clk, rst, res_valid && !res_ready, $stable(res), "result moved")

  // an empty output always lets a request in
  `QAU_ASSERT_NOW(a_ready_free, clk, rst, !res_valid, req_ready, "request blocked")

  // zero quaternion results carry all-zero components
  `QAU_ASSERT_NOW(a_zero_res, clk, rst, res_valid && res.zero_magnitude,
    res.res_real == '0 && res.res_i == '0 && res.res_j == '0 && res.res_k == '0,
    "zero magnitude with non-zero result")

endmodule

bind quaternion_arithmetic_unit_top qau_checker u_qau_checker (.*);
